FILE: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int COLF_W  = 7;
    localparam int ROWF_W  = 5;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [COLOR_W-1:0] FG_WHITE   = 4'hF;
    localparam logic [CELL_W-1:0]  BLANK_CELL = 16'h0F20;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] back_colour;
        logic [COLOR_W-1:0] fore_colour;
        logic [COLF_W-1:0]  col;
        logic [ROWF_W-1:0]  row;
    } t_tcw_cmd;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_tcw_rsp;

    // Side effects of a put on the store.
    typedef struct packed {
        logic store;
        logic scroll;
    } t_put_flags;

endpackage

`default_nettype wire

FILE: rtl/tcw_if.sv
// Valid/ready channel interfaces for the command and response sides.
`default_nettype none

interface tcw_cmd_if
    import tcw_pkg::*;
;
    logic     valid;
    logic     ready;
    t_tcw_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcw_rsp_if
    import tcw_pkg::*;
;
    logic     valid;
    logic     ready;
    t_tcw_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_cursor.sv
// Cursor motion of a put: control codes, tab stops, line wrap and scroll detect.
`default_nettype none

module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8,
    parameter int CW        = 7,
    parameter int RW        = 5
) (
    input  wire logic [CW-1:0]     i_col,
    input  wire logic [RW-1:0]     i_row,
    input  wire logic [CHAR_W-1:0] i_char,
    output logic [CW-1:0]          o_col,
    output logic [RW-1:0]          o_row,
    output t_put_flags             o_flags
);

    localparam int NW    = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int NSTOP = COLUMNS / TAB_WIDTH + 1;

    logic [NW-1:0] col_ext;
    logic [NW-1:0] tab_stop;
    logic [NW-1:0] nc;
    logic [RW:0]   nr;

    assign col_ext = NW'(i_col);

    // First tab stop strictly right of the cursor.
    always_comb begin
        tab_stop = NW'(NSTOP * TAB_WIDTH);
        for (int k = NSTOP; k >= 1; k--) begin
            if (NW'(k * TAB_WIDTH) > col_ext) begin
                tab_stop = NW'(k * TAB_WIDTH);
            end
        end
    end

    always_comb begin
        nc      = col_ext;
        nr      = (RW+1)'(i_row);
        o_flags = '0;
        case (i_char)
            CH_BS: begin
                if (i_col != '0) begin
                    nc = col_ext - NW'(1);
                end
            end
            CH_TAB: begin
                nc = tab_stop;
            end
            CH_CR: begin
                nc = '0;
            end
            CH_LF: begin
                nc = '0;
                nr = nr + (RW+1)'(1);
            end
            default: begin
                if (!i_char[CHAR_W-1] && i_char >= CH_SPACE) begin
                    o_flags.store = 1'b1;
                    nc = col_ext + NW'(1);
                end
            end
        endcase
        // wrap to the next line
        if (nc >= NW'(COLUMNS)) begin
            nc = '0;
            nr = nr + (RW+1)'(1);
        end
        // past the bottom: hold on the last row and scroll
        if (nr >= (RW+1)'(ROWS)) begin
            nr             = (RW+1)'(ROWS - 1);
            o_flags.scroll = 1'b1;
        end
    end

    assign o_col = nc[CW-1:0];
    assign o_row = nr[RW-1:0];

endmodule

`default_nettype wire

FILE: rtl/text_console_writer.sv
// Top level of the character-cell console: screen store, cursor and sweep control.
//
//  channel | dir | handshake          | payload
//  i_cmd   | in  | valid/ready, beat  | op, char_code, back_colour, fore_colour, col, row
//  o_rsp   | out | valid/ready, beat  | cursor_pos, cell_data, scrolled
//
//  Put, set cursor and read cell pass through the accept cycle (store write or read issue
//  on the single-port-pair cell memory) and then load the output register.
//  A scroll first copies rows 1..ROWS-1 up by one row, then fills the bottom row; clear
//  fills all COLUMNS*ROWS cells, one cell per cycle through the memory write port.
//  After reset a clearing pass writes blanks to all COLUMNS*ROWS cells (2000 by default)
//  with i_cmd.ready low. A stalled o_rsp holds its beat; one more command is taken and
//  finished, then waits for the output register.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcw_cmd_if.sink    i_cmd,
    tcw_rsp_if.source  o_rsp
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int PW     = AW + POS_W;

    localparam logic [1:0] S_FILL   = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]        r_state;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [AW-1:0]     r_cnt;
    logic [AW-1:0]     r_cp_addr;
    logic              r_cp_valid;
    logic [CELL_W-1:0] r_fill;
    logic              r_init;
    logic              r_is_read;
    logic              r_scrolled;
    logic              r_out_valid;
    t_tcw_rsp          r_out;
    logic [CELL_W-1:0] r_rd_data;

    logic [CELL_W-1:0] mem [CELLS];

    logic              accept;
    t_tcw_cmd          cmd;
    logic [CW-1:0]     put_col;
    logic [RW-1:0]     put_row;
    t_put_flags        put_flags;
    logic [CW-1:0]     cl_col;
    logic [RW-1:0]     cl_row;
    logic [AW-1:0]     put_addr;
    logic [AW-1:0]     cl_addr;
    logic              copy_rd;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;
    logic              out_free;
    logic [PW-1:0]     pos_wide;

    assign cmd    = i_cmd.data;
    assign accept = i_cmd.valid && (r_state == S_IDLE);

    tcw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH),
        .CW        (CW),
        .RW        (RW)
    ) u_cursor (
        .i_col   (r_col),
        .i_row   (r_row),
        .i_char  (cmd.char_code),
        .o_col   (put_col),
        .o_row   (put_row),
        .o_flags (put_flags)
    );

    // Saturate the requested cell to the screen.
    always_comb begin
        if ((COLF_W+1)'(cmd.col) >= (COLF_W+1)'(COLUMNS)) begin
            cl_col = CW'(COLUMNS - 1);
        end else begin
            cl_col = cmd.col[CW-1:0];
        end
        if ((ROWF_W+2)'(cmd.row) >= (ROWF_W+2)'(ROWS)) begin
            cl_row = RW'(ROWS - 1);
        end else begin
            cl_row = RW'(cmd.row);
        end
    end

    assign put_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign cl_addr  = AW'(cl_row) * AW'(COLUMNS) + AW'(cl_col);
    assign copy_rd  = (r_state == S_SCROLL) && (r_cnt < AW'(COPY_N));

    // Memory port steering.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt;
        mem_wd = r_fill;
        mem_re = 1'b0;
        mem_ra = cl_addr;
        case (r_state)
            S_IDLE: begin
                if (accept && cmd.op == OP_PUT && put_flags.store) begin
                    mem_we = 1'b1;
                    mem_wa = put_addr;
                    mem_wd = {cmd.back_colour, cmd.fore_colour, cmd.char_code};
                end
                mem_re = accept && (cmd.op == OP_READ);
            end
            S_SCROLL: begin
                mem_we = r_cp_valid;
                mem_wa = r_cp_addr;
                mem_wd = r_rd_data;
                mem_re = copy_rd;
                mem_ra = AW'(r_cnt + AW'(COLUMNS));
            end
            S_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign out_free = !r_out_valid || o_rsp.ready;
    assign pos_wide = PW'(r_row) * PW'(COLUMNS) + PW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_cnt       <= '0;
            r_fill      <= BLANK_CELL;
            r_init      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_cp_valid  <= 1'b0;
            r_is_read   <= 1'b0;
            r_scrolled  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_is_read  <= 1'b0;
                        r_scrolled <= 1'b0;
                        r_state    <= S_DONE;
                        case (cmd.op)
                            OP_PUT: begin
                                r_col <= put_col;
                                r_row <= put_row;
                                if (put_flags.scroll) begin
                                    r_scrolled <= 1'b1;
                                    r_cnt      <= '0;
                                    r_cp_valid <= 1'b0;
                                    r_fill     <= BLANK_CELL;
                                    r_state    <= S_SCROLL;
                                end
                            end
                            OP_CLEAR: begin
                                r_col   <= '0;
                                r_row   <= '0;
                                r_cnt   <= '0;
                                r_fill  <= {cmd.back_colour, FG_WHITE, CH_SPACE};
                                r_init  <= 1'b0;
                                r_state <= S_FILL;
                            end
                            OP_SET: begin
                                r_col <= cl_col;
                                r_row <= cl_row;
                            end
                            default: begin
                                r_is_read <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCROLL: begin
                    // copy runs one cell ahead of its write; drain the last one first
                    r_cp_valid <= copy_rd;
                    r_cp_addr  <= r_cnt;
                    if (copy_rd) begin
                        r_cnt <= r_cnt + AW'(1);
                    end else begin
                        r_init  <= 1'b0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_cp_valid <= 1'b0;
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_state <= r_init ? S_IDLE : S_DONE;
                        r_init  <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Raise the output valid with a new beat; drop it once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: loaded on the same edge that raises the output valid.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.cursor_pos <= pos_wide[POS_W-1:0];
            r_out.cell_data  <= r_is_read ? r_rd_data : '0;
            r_out.scrolled   <= r_scrolled;
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level assertions for the console writer, bound to the top level.
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int CELLS = 2000
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [OP_W-1:0]   i_in_op,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [POS_W-1:0]  i_out_pos,
    input wire logic [CELL_W-1:0] i_out_cell,
    input wire logic              i_out_scrolled
);

    // The blanking pass follows reset, so no command is taken right after it.
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("command ready right after reset");

    // A clear walks the whole store before the next command.
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_op == OP_CLEAR) |=> !i_in_ready)
        else $error("command ready right after a clear");

    // Only a put scrolls, and a put returns no cell.
    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_scrolled) |-> i_out_cell == '0)
        else $error("scrolled beat carries cell data");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && CELLS <= 2048) |-> 32'(i_out_pos) < CELLS)
        else $error("cursor position off screen");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("response beat dropped while stalled");

endmodule

bind text_console_writer tcw_checker #(
    .CELLS (COLUMNS * ROWS)
) u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_in_op        (i_cmd.data.op),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_pos      (o_rsp.data.cursor_pos),
    .i_out_cell     (o_rsp.data.cell_data),
    .i_out_scrolled (o_rsp.data.scrolled)
);

`default_nettype wire

FILE: tb/sv/text_console_writer_test.sv
// Self-checking testbench of the text console writer: every reply checked against a console predictor.
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int TAB_WIDTH     = 8;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int CMD_W         = $bits(t_tcw_cmd);
    localparam int RANDOM_ITEMS  = 1825;
    localparam int SETTLE_CYCLES = CELLS + COLUMNS + 200;
    localparam int STALL_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_cmd_if cmd_if ();
    tcw_rsp_if rsp_if ();

    text_console_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    // Predicted console state.
    logic [CELL_W-1:0] screen_model [CELLS];
    int cur_col;
    int cur_row;

    t_tcw_rsp predicted_replies [$];

    int send_idle_pct;
    int rsp_stall_pct;
    int error_count;
    int reply_count;
    int items_sent;
    int scroll_count;
    int op_count [4];
    int stall_cycles;

    always #5 i_clk = ~i_clk;

    function automatic int clamp_to(input int v, input int n);
        return (v >= n) ? n - 1 : v;
    endfunction

    function automatic t_tcw_cmd make_cmd(input logic [OP_W-1:0] op,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [COLOR_W-1:0] back,
                                          input logic [COLOR_W-1:0] fore,
                                          input logic [COLF_W-1:0] col,
                                          input logic [ROWF_W-1:0] row);
        t_tcw_cmd c;
        c.op          = op;
        c.char_code   = ch;
        c.back_colour = back;
        c.fore_colour = fore;
        c.col         = col;
        c.row         = row;
        return c;
    endfunction

    function automatic bit put_char(input t_tcw_cmd c);
        int i;
        case (c.char_code)
            CH_BS: begin
                if (cur_col != 0) cur_col--;
            end
            CH_TAB: cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            CH_CR:  cur_col = 0;
            CH_LF: begin
                cur_col = 0;
                cur_row++;
            end
            default: begin
                // printable range is space up to 0x7F: bit 7 clear
                if (!c.char_code[7] && c.char_code >= CH_SPACE) begin
                    screen_model[cur_row * COLUMNS + cur_col] =
                        {c.back_colour, c.fore_colour, c.char_code};
                    cur_col++;
                end
            end
        endcase
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
            cur_row = ROWS - 1;
            scroll_count++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_tcw_rsp console_step(input t_tcw_cmd c);
        t_tcw_rsp r;
        int i;
        r = '0;
        case (c.op)
            OP_PUT: r.scrolled = put_char(c);
            OP_CLEAR: begin
                for (i = 0; i < CELLS; i++) screen_model[i] = {c.back_colour, FG_WHITE, CH_SPACE};
                cur_col = 0;
                cur_row = 0;
            end
            OP_SET: begin
                cur_col = clamp_to(int'(c.col), COLUMNS);
                cur_row = clamp_to(int'(c.row), ROWS);
            end
            OP_READ: begin
                r.cell_data = screen_model[clamp_to(int'(c.row), ROWS) * COLUMNS +
                                           clamp_to(int'(c.col), COLUMNS)];
            end
        endcase
        r.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) $display("MISMATCH %s", msg);
        error_count++;
    endtask

    task automatic check_reply(input t_tcw_rsp got);
        t_tcw_rsp want;
        reply_count++;
        if (predicted_replies.size() == 0) begin
            report_mismatch($sformatf("reply %0d arrived with nothing pending (pos %0d)",
                                      reply_count, got.cursor_pos));
            return;
        end
        want = predicted_replies.pop_front();
        if (got.cursor_pos !== want.cursor_pos)
            report_mismatch($sformatf("reply %0d cursor_pos got %0d want %0d",
                                      reply_count, got.cursor_pos, want.cursor_pos));
        if (got.cell_data !== want.cell_data)
            report_mismatch($sformatf("reply %0d cell_data got %h want %h",
                                      reply_count, got.cell_data, want.cell_data));
        if (got.scrolled !== want.scrolled)
            report_mismatch($sformatf("reply %0d scrolled got %b want %b",
                                      reply_count, got.scrolled, want.scrolled));
    endtask

    // Send one command beat; predict its reply at the accepting edge.
    task automatic send_cmd(input t_tcw_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        predicted_replies.push_back(console_step(c));
        op_count[c.op]++;
        items_sent++;
    endtask

    task automatic drain_replies();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (predicted_replies.size() != 0);
    endtask

    // Reply side: check each beat, stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready) check_reply(rsp_if.data);
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Watchdog: count cycles without any beat on either side.
    always @(posedge i_clk) begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d replies pending",
                         STALL_LIMIT, predicted_replies.size());
                $display("FAIL text_console_writer");
                $finish;
            end
        end
    end

    task automatic test_reset_state();
        send_cmd(make_cmd(OP_READ, '0, '0, '0, '0, '0));
        // out-of-range read lands on the bottom-right cell
        send_cmd(make_cmd(OP_READ, '0, '0, '0, 7'h7F, 5'h1F));
        drain_replies();
    endtask

    task automatic test_put_and_ignore();
        send_cmd(make_cmd(OP_PUT, CH_SPACE, 4'h0, 4'h0, '0, '0));
        send_cmd(make_cmd(OP_PUT, 8'h7F, 4'hF, 4'hF, '0, '0));
        send_cmd(make_cmd(OP_PUT, 8'h00, 4'h3, 4'h5, '0, '0));
        send_cmd(make_cmd(OP_PUT, 8'h80, 4'h3, 4'h5, '0, '0));
        send_cmd(make_cmd(OP_PUT, 8'hFF, 4'h3, 4'h5, '0, '0));
        send_cmd(make_cmd(OP_PUT, 8'h1B, 4'h3, 4'h5, '0, '0));
        send_cmd(make_cmd(OP_READ, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(OP_READ, '0, '0, '0, 7'd1, '0));
        drain_replies();
    endtask

    task automatic test_control_codes();
        send_cmd(make_cmd(OP_PUT, CH_BS, '0, '0, '0, '0));
        send_cmd(make_cmd(OP_PUT, CH_TAB, '0, '0, '0, '0));
        send_cmd(make_cmd(OP_PUT, CH_CR, '0, '0, '0, '0));
        // backspace at the left margin holds the cursor
        send_cmd(make_cmd(OP_PUT, CH_BS, '0, '0, '0, '0));
        send_cmd(make_cmd(OP_PUT, CH_LF, '0, '0, '0, '0));
        drain_replies();
    endtask

    task automatic test_wrap_and_scroll();
        send_cmd(make_cmd(OP_SET, '0, '0, '0, 7'd72, ROWF_W'(ROWS - 1)));
        send_cmd(make_cmd(OP_PUT, CH_TAB, '0, '0, '0, '0));
        send_cmd(make_cmd(OP_SET, '0, '0, '0, COLF_W'(COLUMNS - 1), ROWF_W'(ROWS - 1)));
        send_cmd(make_cmd(OP_PUT, 8'h41, 4'h2, 4'hA, '0, '0));
        send_cmd(make_cmd(OP_READ, '0, '0, '0, COLF_W'(COLUMNS - 1), ROWF_W'(ROWS - 2)));
        send_cmd(make_cmd(OP_PUT, CH_LF, '0, '0, '0, '0));
        drain_replies();
    endtask

    task automatic test_clear_and_home();
        send_cmd(make_cmd(OP_CLEAR, '0, 4'hF, '0, '0, '0));
        send_cmd(make_cmd(OP_READ, '0, '0, '0, 7'd40, 5'd12));
        send_cmd(make_cmd(OP_CLEAR, '0, 4'h0, '0, '0, '0));
        send_cmd(make_cmd(OP_SET, '0, '0, '0, 7'h7F, 5'h1F));
        drain_replies();
    endtask

    // Mostly runs of text with cursor moves and reads between them, plus raw noise.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        int run_len;
        int k;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                run_len = $urandom_range(24, 1);
                for (k = 0; k < run_len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 80) ch = CH_SPACE + CHAR_W'($urandom_range(95));
                    else if (pick < 86) ch = CH_LF;
                    else if (pick < 90) ch = CH_TAB;
                    else if (pick < 93) ch = CH_BS;
                    else if (pick < 96) ch = CH_CR;
                    else if (pick < 98) ch = CHAR_W'($urandom_range(31));
                    else ch = CHAR_W'($urandom_range(255, 128));
                    send_cmd(make_cmd(OP_PUT, ch, COLOR_W'($urandom), COLOR_W'($urandom),
                                      COLF_W'($urandom), ROWF_W'($urandom)));
                end
                sent += run_len;
            end else begin
                if (pick < 40) begin
                    send_cmd(make_cmd(OP_SET, CHAR_W'($urandom), COLOR_W'($urandom),
                                      COLOR_W'($urandom), COLF_W'($urandom),
                                      ROWF_W'($urandom)));
                end else if (pick < 45) begin
                    // park near the bottom so text soon scrolls
                    send_cmd(make_cmd(OP_SET, CHAR_W'($urandom), COLOR_W'($urandom),
                                      COLOR_W'($urandom),
                                      COLF_W'($urandom_range(COLUMNS - 1)),
                                      ROWF_W'($urandom_range(ROWS - 1, ROWS - 5))));
                end else if (pick < 50) begin
                    send_cmd(make_cmd(OP_SET, CHAR_W'($urandom), COLOR_W'($urandom),
                                      COLOR_W'($urandom),
                                      COLF_W'($urandom_range(COLUMNS - 1)),
                                      ROWF_W'($urandom_range(ROWS - 1))));
                end else if (pick < 70) begin
                    send_cmd(make_cmd(OP_READ, CHAR_W'($urandom), COLOR_W'($urandom),
                                      COLOR_W'($urandom), COLF_W'($urandom),
                                      ROWF_W'($urandom)));
                end else if (pick < 85) begin
                    // look back at the cell just left of the cursor
                    send_cmd(make_cmd(OP_READ, CHAR_W'($urandom), COLOR_W'($urandom),
                                      COLOR_W'($urandom),
                                      COLF_W'((cur_col > 0) ? cur_col - 1 : 0),
                                      ROWF_W'(cur_row)));
                end else if (pick < 88) begin
                    send_cmd(make_cmd(OP_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom),
                                      COLOR_W'($urandom), COLF_W'($urandom),
                                      ROWF_W'($urandom)));
                end else begin
                    send_cmd(t_tcw_cmd'(CMD_W'($urandom)));
                end
                sent++;
            end
        end
        drain_replies();
    endtask

    initial begin
        int i;
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        rsp_if.ready  = 1'b0;
        error_count   = 0;
        reply_count   = 0;
        items_sent    = 0;
        scroll_count  = 0;
        stall_cycles  = 0;
        op_count      = '{default: 0};
        for (i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;

        send_idle_pct = 28;
        rsp_stall_pct = 45;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_put_and_ignore();
        test_control_codes();
        test_wrap_and_scroll();
        test_clear_and_home();

        test_random_traffic(RANDOM_ITEMS / 3);
        send_idle_pct = 45;
        rsp_stall_pct = 28;
        test_random_traffic(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (predicted_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", predicted_replies.size()));

        $display("ran %0d commands: %0d puts, %0d clears, %0d cursor sets, %0d cell reads",
                 items_sent, op_count[OP_PUT], op_count[OP_CLEAR], op_count[OP_SET],
                 op_count[OP_READ]);
        $display("%0d scrolls, %0d replies checked, %0d mismatches",
                 scroll_count, reply_count, error_count);
        if (error_count == 0) begin
            $display("PASS text_console_writer");
        end else begin
            $display("FAIL text_console_writer");
        end
        $finish;
    end

endmodule
